FILE: hdl/bitmap_free_bit_allocator_assert.svh
// Assertion macros for the bitmap free-bit allocator.
// Used by the top level; expects clk and arst_n in scope.
`ifndef BITMAP_FREE_BIT_ALLOCATOR_ASSERT_SVH
`define BITMAP_FREE_BIT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FBAL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define FBAL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/fbal_pkg.sv
// Shared constants and types of the bitmap free-bit allocator.
// No dependencies; used by every module of the block.
package fbal_pkg;

	localparam int WORD_BITS   = 64;
	localparam int BLOCK_BITS  = 4096;
	localparam int NUM_BLOCKS  = 8;
	localparam int TOTAL_BITS  = NUM_BLOCKS * BLOCK_BITS;
	localparam int STORE_WORDS = TOTAL_BITS / WORD_BITS;
	localparam int SCAN_WORDS  = BLOCK_BITS / WORD_BITS;

	localparam int POS_W   = $clog2(WORD_BITS);
	localparam int ADDR_W  = $clog2(STORE_WORDS);
	localparam int BLK_W   = $clog2(NUM_BLOCKS);
	localparam int SCAN_W  = $clog2(SCAN_WORDS);
	localparam int OFF_W   = $clog2(BLOCK_BITS);
	localparam int GBIT_W  = $clog2(TOTAL_BITS);
	localparam int CFG_W   = 16;

	localparam int IN_W  = 96;
	localparam int OUT_W = 88;

	typedef enum logic [2:0] {
		OP_WRITE      = 3'd0,
		OP_READ       = 3'd1,
		OP_FIND_INODE = 3'd2,
		OP_FIND_DATA  = 3'd3,
		OP_SET        = 3'd4,
		OP_CLEAR      = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		REG_INODE_BASE = 2'd0,
		REG_DATA_START = 2'd1,
		REG_DATA_STOP  = 2'd2
	} reg_t;

	// Search window relative to the block start; hi may equal BLOCK_BITS.
	typedef struct packed {
		logic [OFF_W-1:0] lo;
		logic [OFF_W:0]   hi;
	} win_t;

endpackage

FILE: hdl/fbal_ram.sv
// Single-port bitmap word store with registered read data.
// Depends on fbal_pkg for the store geometry.
module fbal_ram (
	input  logic                          clk,
	input  logic [fbal_pkg::ADDR_W-1:0]   addr,
	input  logic                          we,
	input  logic [fbal_pkg::WORD_BITS-1:0] wdata,
	output logic [fbal_pkg::WORD_BITS-1:0] rdata
);
	import fbal_pkg::*;

	logic [WORD_BITS-1:0] mem [STORE_WORDS];
	logic [WORD_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/fbal_scan.sv
// Window mask and free-bit extraction for one bitmap word of a block.
// Depends on fbal_pkg; used once per cycle by the find sequencer.
module fbal_scan (
	input  logic [fbal_pkg::WORD_BITS-1:0] word,
	input  logic [fbal_pkg::SCAN_W-1:0]    idx,
	input  fbal_pkg::win_t                 win,
	output logic [fbal_pkg::WORD_BITS-1:0] free
);
	import fbal_pkg::*;

	logic [SCAN_W-1:0]    lo_w;
	logic [POS_W-1:0]     lo_b;
	logic [SCAN_W:0]      hi_w;
	logic [POS_W-1:0]     hi_b;
	logic [SCAN_W:0]      idx_x;
	logic [WORD_BITS-1:0] ge_mask;
	logic [WORD_BITS-1:0] lt_mask;

	assign lo_w  = win.lo[OFF_W-1:POS_W];
	assign lo_b  = win.lo[POS_W-1:0];
	assign hi_w  = win.hi[OFF_W:POS_W];
	assign hi_b  = win.hi[POS_W-1:0];
	assign idx_x = {1'b0, idx};

	always_comb begin
		if (idx < lo_w) begin
			ge_mask = '0;
		end else if (idx == lo_w) begin
			ge_mask = {WORD_BITS{1'b1}} << lo_b;
		end else begin
			ge_mask = '1;
		end
		if (idx_x < hi_w) begin
			lt_mask = '1;
		end else if (idx_x == hi_w) begin
			lt_mask = ({{(WORD_BITS-1){1'b0}}, 1'b1} << hi_b) - 1'b1;
		end else begin
			lt_mask = '0;
		end
	end

	// A 1 in the bitmap means used, so free bits are the zeros in the window.
	assign free = ~word & ge_mask & lt_mask;

endmodule

FILE: hdl/fbal_ffs.sv
// Lowest-set-bit encoder for one word of free bits.
// Depends on fbal_pkg for the word width.
module fbal_ffs (
	input  logic [fbal_pkg::WORD_BITS-1:0] vec,
	output logic [fbal_pkg::POS_W-1:0]     pos
);
	import fbal_pkg::*;

	logic [WORD_BITS-1:0] low_one;

	// Two's complement isolates the lowest one; the rest is a one-hot encode.
	assign low_one = vec & (~vec + 1'b1);

	always_comb begin
		pos = '0;
		for (int k = 0; k < POS_W; k++) begin
			for (int j = 0; j < WORD_BITS; j++) begin
				if (((j >> k) & 1) == 1) begin
					pos[k] = pos[k] | low_one[j];
				end
			end
		end
	end

endmodule

FILE: hdl/bitmap_free_bit_allocator.sv
// Bitmap free-bit allocator: usage.
// Input items arrive on s_tvalid/s_tready/s_tdata and each gives exactly one
// result item on m_tvalid/m_tready/m_tdata. Region limits are loaded through
// cfg_we/cfg_index/cfg_data; the user must load them only while the block is
// idle, which the block itself does not enforce. After acceptance, word
// writes and rejected items go straight to S_OUT; a word read passes S_RD,
// set and clear pass S_RMW; a find passes S_WIN and, unless the window is
// empty, S_FIND and, on a hit, S_ENC. One sequencer walks the 64 words of
// the block through the single memory port, one word a cycle, and stops at
// the first word with a free bit. One item is in work at a time; s_tready is
// low from acceptance until the result is loaded into the output register,
// and the next item can be accepted in the cycle after that load. The next
// item is accepted while that result still waits for m_tready.
// Reset clears the region registers to zero and the control state; the bitmap
// store itself is not cleared and must be loaded by word writes before use.
// A stalled receiver holds the output register and, once an item is done,
// keeps the block from loading the next result.
// Depends on fbal_pkg, fbal_ram, fbal_scan and fbal_ffs.
`include "bitmap_free_bit_allocator_assert.svh"

module bitmap_free_bit_allocator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// opcode[2:0], word_index[11:3], word_data[75:12], block_index[78:76],
	// bit_address[93:79], zero fill above
	input  logic [fbal_pkg::IN_W-1:0]    s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// free_index[14:0], found[15], read_data[79:16], status[80], zero fill above
	output logic [fbal_pkg::OUT_W-1:0]   m_tdata,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [fbal_pkg::CFG_W-1:0]   cfg_data
);
	import fbal_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WIN,
		S_FIND,
		S_ENC,
		S_RD,
		S_RMW,
		S_OUT
	} state_t;

	state_t st_q;

	logic [CFG_W-1:0] inode_base_q;
	logic [CFG_W-1:0] data_start_q;
	logic [CFG_W-1:0] data_stop_q;

	// Input fields.
	logic [2:0]           in_opcode;
	logic [ADDR_W-1:0]    in_word_index;
	logic [WORD_BITS-1:0] in_word_data;
	logic [BLK_W-1:0]     in_block_index;
	logic [GBIT_W-1:0]    in_bit_address;
	logic                 accept;
	logic                 addr_ok;

	// Working registers.
	logic [BLK_W-1:0]     blk_q;
	logic [CFG_W-1:0]     lo_q;
	logic [CFG_W-1:0]     hi_q;
	win_t                 win_q;
	logic [SCAN_W:0]      cnt_q;
	logic [ADDR_W-1:0]    waddr_q;
	logic [POS_W-1:0]     bpos_q;
	logic                 set_q;
	logic [WORD_BITS-1:0] hit_free_q;
	logic [SCAN_W-1:0]    hit_word_q;

	// Pending result.
	logic [GBIT_W-1:0]    res_free_q;
	logic                 res_found_q;
	logic [WORD_BITS-1:0] res_data_q;
	logic                 res_status_q;

	// Output register.
	logic                 m_tvalid_q;
	logic                 out_load;
	logic [GBIT_W-1:0]    out_free_q;
	logic                 out_found_q;
	logic [WORD_BITS-1:0] out_data_q;
	logic                 out_status_q;

	// Memory and scan unit wiring.
	logic [ADDR_W-1:0]    mem_addr;
	logic                 mem_we;
	logic [WORD_BITS-1:0] mem_wdata;
	logic [WORD_BITS-1:0] mem_rdata;
	logic [SCAN_W-1:0]    chk_idx;
	logic [WORD_BITS-1:0] scan_free;
	logic [POS_W-1:0]     hit_pos;
	logic [WORD_BITS-1:0] bit_mask;

	// Window clipping to the block.
	logic [CFG_W-1:0]     b_lo;
	logic [CFG_W-1:0]     b_hi;
	logic [CFG_W-1:0]     lo_c;
	logic [CFG_W-1:0]     hi_c;
	logic [CFG_W-1:0]     lo_rel;
	logic [CFG_W-1:0]     hi_rel;

	assign in_opcode      = s_tdata[2:0];
	assign in_word_index  = s_tdata[11:3];
	assign in_word_data   = s_tdata[75:12];
	assign in_block_index = s_tdata[78:76];
	assign in_bit_address = s_tdata[93:79];

	assign s_tready = (st_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign addr_ok  = ({1'b0, in_bit_address} >= inode_base_q)
		&& ({1'b0, in_bit_address} < data_stop_q);

	assign b_lo   = {1'b0, blk_q, {OFF_W{1'b0}}};
	assign b_hi   = b_lo + CFG_W'(BLOCK_BITS);
	assign lo_c   = (lo_q > b_lo) ? lo_q : b_lo;
	assign hi_c   = (hi_q < b_hi) ? hi_q : b_hi;
	assign lo_rel = lo_c - b_lo;
	assign hi_rel = hi_c - b_lo;

	assign chk_idx  = SCAN_W'(cnt_q - 1'b1);
	assign bit_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << bpos_q;

	assign out_load = (st_q == S_OUT) && (!m_tvalid_q || m_tready);

	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = in_word_data;
		unique case (st_q)
			S_FIND: begin
				mem_addr = {blk_q, cnt_q[SCAN_W-1:0]};
			end
			S_RMW: begin
				mem_addr  = waddr_q;
				mem_we    = 1'b1;
				mem_wdata = set_q ? (mem_rdata | bit_mask) : (mem_rdata & ~bit_mask);
			end
			S_IDLE: begin
				if (in_opcode == OP_SET || in_opcode == OP_CLEAR) begin
					mem_addr = in_bit_address[GBIT_W-1:POS_W];
				end else begin
					mem_addr = in_word_index;
				end
				mem_we = accept && (in_opcode == OP_WRITE);
			end
			default: begin
				mem_addr = waddr_q;
			end
		endcase
	end

	fbal_ram u_ram (
		.clk   (clk),
		.addr  (mem_addr),
		.we    (mem_we),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	fbal_scan u_scan (
		.word (mem_rdata),
		.idx  (chk_idx),
		.win  (win_q),
		.free (scan_free)
	);

	fbal_ffs u_ffs (
		.vec (hit_free_q),
		.pos (hit_pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inode_base_q <= '0;
			data_start_q <= '0;
			data_stop_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INODE_BASE: inode_base_q <= cfg_data;
				REG_DATA_START: data_start_q <= cfg_data;
				REG_DATA_STOP:  data_stop_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			m_tvalid_q   <= 1'b0;
			cnt_q        <= '0;
			blk_q        <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
			win_q        <= '0;
			waddr_q      <= '0;
			bpos_q       <= '0;
			set_q        <= 1'b0;
			hit_free_q   <= '0;
			hit_word_q   <= '0;
			res_free_q   <= '0;
			res_found_q  <= 1'b0;
			res_data_q   <= '0;
			res_status_q <= 1'b0;
			out_free_q   <= '0;
			out_found_q  <= 1'b0;
			out_data_q   <= '0;
			out_status_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (accept) begin
						res_free_q   <= '0;
						res_found_q  <= 1'b0;
						res_data_q   <= '0;
						res_status_q <= 1'b0;
						blk_q        <= in_block_index;
						waddr_q      <= in_bit_address[GBIT_W-1:POS_W];
						bpos_q       <= in_bit_address[POS_W-1:0];
						set_q        <= (in_opcode == OP_SET);
						cnt_q        <= '0;
						unique case (in_opcode)
							OP_WRITE: st_q <= S_OUT;
							OP_READ:  st_q <= S_RD;
							OP_FIND_INODE: begin
								lo_q <= inode_base_q;
								hi_q <= data_start_q;
								st_q <= S_WIN;
							end
							OP_FIND_DATA: begin
								lo_q <= data_start_q;
								hi_q <= data_stop_q;
								st_q <= S_WIN;
							end
							OP_SET, OP_CLEAR: begin
								res_status_q <= !addr_ok;
								st_q         <= addr_ok ? S_RMW : S_OUT;
							end
							default: begin
								res_status_q <= 1'b1;
								st_q         <= S_OUT;
							end
						endcase
					end
				end
				S_WIN: begin
					win_q.lo <= lo_rel[OFF_W-1:0];
					win_q.hi <= hi_rel[OFF_W:0];
					// An empty or inverted window finds nothing without a scan.
					st_q <= (lo_c < hi_c) ? S_FIND : S_OUT;
				end
				S_FIND: begin
					if (cnt_q != '0 && scan_free != '0) begin
						hit_free_q <= scan_free;
						hit_word_q <= chk_idx;
						st_q       <= S_ENC;
					end else if (cnt_q == (SCAN_W+1)'(SCAN_WORDS)) begin
						st_q <= S_OUT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_ENC: begin
					res_free_q  <= {blk_q, hit_word_q, hit_pos};
					res_found_q <= 1'b1;
					st_q        <= S_OUT;
				end
				S_RD: begin
					res_data_q <= mem_rdata;
					st_q       <= S_OUT;
				end
				S_RMW: begin
					st_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						out_free_q   <= res_free_q;
						out_found_q  <= res_found_q;
						out_data_q   <= res_data_q;
						out_status_q <= res_status_q;
						st_q         <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, out_status_q, out_data_q, out_found_q, out_free_q};

	`FBAL_ASSERT_NEXT(a_busy_after_accept, accept, !s_tready, "accepted item did not make the block busy")
	`FBAL_ASSERT_NOW(a_found_clean, m_tvalid_q && out_found_q, !out_status_q && out_data_q == '0, "found result carries status or data")
	`FBAL_ASSERT_NOW(a_hit_nonzero, st_q == S_ENC, hit_free_q != '0, "encoder entered without a free bit")
	`FBAL_ASSERT_NOW(a_scan_bound, st_q == S_FIND, cnt_q <= (SCAN_W+1)'(SCAN_WORDS), "scan counter ran past the block")

endmodule
